// File: hw/rtl/brsg_pkg.sv
// ----------------------------------------------------------------------------
// brsg_pkg
// Shared constants, step codes and controller/datapath interface structs for
// the binomial-tree reduce schedule generator.
// ----------------------------------------------------------------------------
package brsg_pkg;

    localparam int MAX_RANKS   = 1024;
    localparam int RANK_W      = $clog2(MAX_RANKS);
    localparam int GS_W        = RANK_W + 1;
    localparam int TDATA_W     = ((RANK_W + 7) / 8) * 8;
    localparam int IN_TUSER_W  = 2;
    localparam int KIND_W      = 3;
    localparam int CFG_ADDR_W  = 1;

    localparam logic [CFG_ADDR_W-1:0] CFG_GROUP_SIZE = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MY_RANK    = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        OP_COPY_IN   = 3'd0,
        OP_RECV_TEMP = 3'd1,
        OP_RED_TA    = 3'd2,
        OP_RED_AT    = 3'd3,
        OP_COPY_BACK = 3'd4,
        OP_SEND      = 3'd5,
        OP_RECV_ACC  = 3'd6,
        OP_ERROR     = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        PEER_ZERO,
        PEER_CHILD,
        PEER_PARENT,
        PEER_ROOT
    } t_peer_sel;

    typedef struct packed {
        logic      load;
        logic      setup;
        logic      emit;
        t_op       kind;
        t_peer_sel peer_sel;
        logic      mask_shift;
        logic      flush;
    } t_cmd;

    typedef struct packed {
        logic err;
        logic need_copy;
        logic mask_lt_gs;
        logic mask_hit;
        logic child_lt_gs;
        logic comm;
        logic root_nz;
        logic rank_zero;
        logic rank_is_root;
        logic emit_ok;
        logic flush_ok;
    } t_stat;

endpackage

// File: hw/rtl/brsg_dp.sv
// ----------------------------------------------------------------------------
// brsg_dp
// Datapath: config registers, latched request, tree level state, peer
// arithmetic, one-step hold stage (to place the last flag) and output register.
// ----------------------------------------------------------------------------
module brsg_dp
    import brsg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [GS_W-1:0]       i_cfg_wdata,
    input  logic [RANK_W-1:0]     i_root,
    input  logic                  i_comm,
    input  logic                  i_inpl,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    input  logic                  i_m_ready,
    output logic                  o_m_valid,
    output t_op                   o_m_kind,
    output logic [RANK_W-1:0]     o_m_peer,
    output logic                  o_m_last
);

    logic [GS_W-1:0]   r_gs;
    logic [RANK_W-1:0] r_rank;
    logic [RANK_W-1:0] r_root;
    logic              r_comm;
    logic              r_inpl;
    logic [RANK_W-1:0] r_rel;
    logic [GS_W-1:0]   r_mask;

    logic              r_pend_vld;
    t_op               r_pend_kind;
    logic [RANK_W-1:0] r_pend_peer;
    logic              r_out_vld;
    t_op               r_out_kind;
    logic [RANK_W-1:0] r_out_peer;
    logic              r_out_last;

    logic [RANK_W-1:0] lroot;
    logic [GS_W-1:0]   n_rel;
    logic [RANK_W-1:0] child;
    logic [RANK_W-1:0] parent_rel;
    logic [RANK_W-1:0] wrap_op;
    logic [GS_W-1:0]   wrap_sum;
    logic [GS_W-1:0]   wrap_res;
    logic [RANK_W-1:0] peer_val;
    logic              out_free;
    logic              move;

    assign lroot      = r_comm ? r_root : '0;
    assign n_rel      = ({1'b0, r_rank} >= {1'b0, lroot})
                      ? ({1'b0, r_rank} - {1'b0, lroot})
                      : ({1'b0, r_rank} + r_gs - {1'b0, lroot});
    assign child      = r_rel | r_mask[RANK_W-1:0];
    assign parent_rel = r_rel & ~r_mask[RANK_W-1:0];
    assign wrap_op    = (i_cmd.peer_sel == PEER_CHILD) ? child : parent_rel;
    assign wrap_sum   = {1'b0, wrap_op} + {1'b0, lroot};
    assign wrap_res   = (wrap_sum >= r_gs) ? (wrap_sum - r_gs) : wrap_sum;

    always_comb begin
        unique case (i_cmd.peer_sel)
            PEER_ZERO:   peer_val = '0;
            PEER_CHILD:  peer_val = wrap_res[RANK_W-1:0];
            PEER_PARENT: peer_val = wrap_res[RANK_W-1:0];
            PEER_ROOT:   peer_val = r_root;
            default:     peer_val = '0;
        endcase
    end

    assign out_free = !r_out_vld || i_m_ready;
    assign move     = r_pend_vld && (i_cmd.emit || i_cmd.flush);

    always_comb begin
        o_stat.err          = (r_gs == '0) || (r_gs > GS_W'(MAX_RANKS))
                           || ({1'b0, r_root} >= r_gs) || ({1'b0, r_rank} >= r_gs);
        o_stat.need_copy    = (r_rank != r_root) || !r_inpl;
        o_stat.mask_lt_gs   = r_mask < r_gs;
        o_stat.mask_hit     = |(r_mask[RANK_W-1:0] & r_rel);
        o_stat.child_lt_gs  = {1'b0, child} < r_gs;
        o_stat.comm         = r_comm;
        o_stat.root_nz      = r_root != '0;
        o_stat.rank_zero    = r_rank == '0;
        o_stat.rank_is_root = r_rank == r_root;
        o_stat.emit_ok      = !r_pend_vld || out_free;
        o_stat.flush_ok     = !r_pend_vld || out_free;
    end

    // control and config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gs       <= GS_W'(1);
            r_rank     <= '0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_GROUP_SIZE: r_gs   <= i_cfg_wdata;
                    CFG_MY_RANK:    r_rank <= i_cfg_wdata[RANK_W-1:0];
                    default:        r_gs   <= r_gs;
                endcase
            end
            if (i_cmd.emit) begin
                r_pend_vld <= 1'b1;
            end else if (i_cmd.flush) begin
                r_pend_vld <= 1'b0;
            end
            if (move) begin
                r_out_vld <= 1'b1;
            end else if (i_m_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_root <= i_root;
            r_comm <= i_comm;
            r_inpl <= i_inpl;
        end
        if (i_cmd.setup) begin
            r_rel  <= n_rel[RANK_W-1:0];
            r_mask <= GS_W'(1);
        end else if (i_cmd.mask_shift) begin
            r_mask <= {r_mask[GS_W-2:0], 1'b0};
        end
        if (i_cmd.emit) begin
            r_pend_kind <= i_cmd.kind;
            r_pend_peer <= peer_val;
        end
        if (move) begin
            r_out_kind <= r_pend_kind;
            r_out_peer <= r_pend_peer;
            r_out_last <= i_cmd.flush;
        end
    end

    assign o_m_valid = r_out_vld;
    assign o_m_kind  = r_out_kind;
    assign o_m_peer  = r_out_peer;
    assign o_m_last  = r_out_last;

endmodule

// File: hw/rtl/brsg_ctrl.sv
// ----------------------------------------------------------------------------
// brsg_ctrl
// Controller: walks the schedule (copy in, tree levels, final hop) and issues
// one step command per cycle to the datapath, emitting a step only while the output can take it.
// ----------------------------------------------------------------------------
module brsg_ctrl
    import brsg_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_valid,
    output logic  o_s_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SETUP,
        S_COPY,
        S_LEVEL,
        S_RECV,
        S_RED,
        S_CBACK,
        S_HOP,
        S_FLUSH
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.kind     = OP_COPY_IN;
        o_cmd.peer_sel = PEER_ZERO;
        o_s_ready      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SETUP;
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                if (i_stat.err) begin
                    if (i_stat.emit_ok) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.kind = OP_ERROR;
                        n_state    = S_FLUSH;
                    end
                end else begin
                    n_state = i_stat.need_copy ? S_COPY : S_LEVEL;
                end
            end
            S_COPY: begin
                if (i_stat.emit_ok) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = OP_COPY_IN;
                    n_state    = S_LEVEL;
                end
            end
            S_LEVEL: begin
                if (!i_stat.mask_lt_gs) begin
                    n_state = S_HOP;
                end else if (i_stat.mask_hit) begin
                    if (i_stat.emit_ok) begin
                        o_cmd.emit     = 1'b1;
                        o_cmd.kind     = OP_SEND;
                        o_cmd.peer_sel = PEER_PARENT;
                        n_state        = S_HOP;
                    end
                end else if (i_stat.child_lt_gs) begin
                    n_state = S_RECV;
                end else begin
                    o_cmd.mask_shift = 1'b1;
                end
            end
            S_RECV: begin
                if (i_stat.emit_ok) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.kind     = OP_RECV_TEMP;
                    o_cmd.peer_sel = PEER_CHILD;
                    n_state        = S_RED;
                end
            end
            S_RED: begin
                if (i_stat.emit_ok) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.comm) begin
                        o_cmd.kind       = OP_RED_TA;
                        o_cmd.mask_shift = 1'b1;
                        n_state          = S_LEVEL;
                    end else begin
                        o_cmd.kind = OP_RED_AT;
                        n_state    = S_CBACK;
                    end
                end
            end
            S_CBACK: begin
                if (i_stat.emit_ok) begin
                    o_cmd.emit       = 1'b1;
                    o_cmd.kind       = OP_COPY_BACK;
                    o_cmd.mask_shift = 1'b1;
                    n_state          = S_LEVEL;
                end
            end
            S_HOP: begin
                if (!i_stat.comm && i_stat.root_nz
                    && (i_stat.rank_zero || i_stat.rank_is_root)) begin
                    if (i_stat.emit_ok) begin
                        o_cmd.emit = 1'b1;
                        if (i_stat.rank_zero) begin
                            o_cmd.kind     = OP_SEND;
                            o_cmd.peer_sel = PEER_ROOT;
                        end else begin
                            o_cmd.kind = OP_RECV_ACC;
                        end
                        n_state = S_FLUSH;
                    end
                end else begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (i_stat.flush_ok) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: hw/rtl/binomial_reduce_schedule_gen_core.sv
// ----------------------------------------------------------------------------
// binomial_reduce_schedule_gen_core
// Binomial-tree reduce schedule generator: one request in, the ordered list
// of copy/receive/reduce/send steps for this rank out.
//
//   channel   dir  handshake               payload
//   s_axis    in   tvalid/tready           tdata: root; tuser: commutative, in_place
//   m_axis    out  tvalid/tready, tlast    tdata: peer; tuser: op_kind
//   cfg       in   i_cfg_we                i_cfg_addr, i_cfg_wdata
//
// One request at a time; the controller emits at most one step per cycle. A
// request runs through idle, setup and, if needed, copy, then for each tree
// level up to the level check, receive, reduce and copy-back states, then the
// closing level check, hop and flush, before the next request is accepted.
// A one-step hold stage places tlast; the output register lets the next step
// be built while the previous one waits. m_axis stalls hold the controller.
// Synchronous active-low reset; config resets to group_size 1, my_rank 0.
// ----------------------------------------------------------------------------
module binomial_reduce_schedule_gen_core
    import brsg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [GS_W-1:0]       i_cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [TDATA_W-1:0]    s_axis_tdata,  // root
    input  logic [IN_TUSER_W-1:0] s_axis_tuser,  // commutative, in_place
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [TDATA_W-1:0]    m_axis_tdata,  // peer
    output logic [KIND_W-1:0]     m_axis_tuser,  // op_kind
    output logic                  m_axis_tlast
);

    t_cmd              cmd;
    t_stat             stat;
    t_op               out_kind;
    logic [RANK_W-1:0] out_peer;

    brsg_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    brsg_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_root      (s_axis_tdata[RANK_W-1:0]),
        .i_comm      (s_axis_tuser[0]),
        .i_inpl      (s_axis_tuser[1]),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_m_ready   (m_axis_tready),
        .o_m_valid   (m_axis_tvalid),
        .o_m_kind    (out_kind),
        .o_m_peer    (out_peer),
        .o_m_last    (m_axis_tlast)
    );

    assign m_axis_tdata = TDATA_W'(out_peer);
    assign m_axis_tuser = out_kind;

endmodule

// File: hw/rtl/brsg_checker.sv
// ----------------------------------------------------------------------------
// brsg_checker
// Port-level checks on the schedule generator, bound to the top level.
// ----------------------------------------------------------------------------
module brsg_checker
    import brsg_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [TDATA_W-1:0]    m_axis_tdata,
    input logic [KIND_W-1:0]     m_axis_tuser,
    input logic                  m_axis_tlast
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("stalled result request dropped");

    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == OP_ERROR) |-> m_axis_tlast && (m_axis_tdata == '0))
        else $error("error step not a lone last step with zero peer");

    a_peer_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == OP_COPY_IN || m_axis_tuser == OP_RED_TA
            || m_axis_tuser == OP_RED_AT || m_axis_tuser == OP_COPY_BACK
            || m_axis_tuser == OP_RECV_ACC)
        |-> m_axis_tdata == '0)
        else $error("local step carries a nonzero peer");

    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second request taken while one is in progress");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result request right after reset");

endmodule

bind binomial_reduce_schedule_gen_core brsg_checker u_brsg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
